### design/swm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    // Capacity of the pattern store, in bytes.
    localparam int PAT_MAX = 32;
    // Width of a pattern length or a position index (0..PAT_MAX).
    localparam int LEN_W = $clog2(PAT_MAX + 1);
    // Number of prefix levels that close a position set over stars.
    localparam int CLOSE_LEVELS = $clog2(PAT_MAX + 1);

    localparam logic [7:0] STAR_CODE = 8'd42;

    typedef enum logic
    {
        REQ_PATTERN = 1'b0,
        REQ_TEXT    = 1'b1
    } req_type_t;

    typedef struct packed
    {
        req_type_t  req_type;
        logic [7:0] char_code;
        logic       no_char;
        logic       last;
    } swm_item_t;

    typedef struct packed
    {
        logic pattern_overflow;
        logic matched;
    } swm_result_t;

endpackage

`default_nettype wire

### design/swm_closure.sv
`timescale 1ns / 1ps
`default_nettype none

// Closes a set of pattern positions over stars: a star at position p that is
// in the set pulls position p+1 in as well. Built as a parallel prefix, where
// a set bit generates and a star in front of a position propagates into it.
module swm_closure
(
    input  wire logic [swm_pkg::PAT_MAX:0]   seed,
    input  wire logic [swm_pkg::PAT_MAX-1:0] star,
    output logic      [swm_pkg::PAT_MAX:0]   closed
);
    import swm_pkg::*;

    logic [PAT_MAX:0] gen_lvl [0:CLOSE_LEVELS];
    logic [PAT_MAX:0] prop_lvl [0:CLOSE_LEVELS];

    assign gen_lvl[0]  = seed;
    assign prop_lvl[0] = {star, 1'b0};

    for (genvar l = 0; l < CLOSE_LEVELS; l++)
    begin : g_level
        localparam int DIST = 1 << l;
        for (genvar i = 0; i <= PAT_MAX; i++)
        begin : g_bit
            if (i >= DIST)
            begin : g_combine
                assign gen_lvl[l+1][i] = gen_lvl[l][i]
                                       | (prop_lvl[l][i] & gen_lvl[l][i-DIST]);
                assign prop_lvl[l+1][i] = prop_lvl[l][i] & prop_lvl[l][i-DIST];
            end
            else
            begin : g_pass
                assign gen_lvl[l+1][i]  = gen_lvl[l][i];
                assign prop_lvl[l+1][i] = prop_lvl[l][i];
            end
        end
    end

    assign closed = gen_lvl[CLOSE_LEVELS];

endmodule

`default_nettype wire

### design/swm_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Pattern store and active-position state. One item is applied per cycle
// when step is high; the result of a text item is valid in the same cycle.
module swm_engine
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire swm_pkg::swm_item_t  item,
    output swm_pkg::swm_result_t     result
);
    import swm_pkg::*;

    logic [7:0]       chr_reg [0:PAT_MAX-1];
    logic [PAT_MAX-1:0] star_reg;
    logic [LEN_W-1:0] len_reg;
    logic             loading_reg;
    logic             ovf_reg;
    logic [PAT_MAX:0] active_reg;
    // Closure of position zero for the stored pattern, kept up to date as
    // the pattern loads so a restart costs nothing.
    logic [PAT_MAX:0] cl0_reg;

    logic [LEN_W-1:0]   load_base;
    logic               ovf_base;
    logic [PAT_MAX:0]   cl0_base;
    logic [PAT_MAX:0]   cl0_ext;
    logic [PAT_MAX:0]   cl0_next;
    logic               is_star_c;
    logic               store_full;
    logic               wr_en;
    logic [PAT_MAX-1:0] valid_mask;
    logic [PAT_MAX-1:0] star_v;
    logic [PAT_MAX-1:0] lit_match;
    logic [PAT_MAX:0]   act;
    logic [PAT_MAX:0]   seed;
    logic [PAT_MAX:0]   adv;
    logic [PAT_MAX:0]   cur;
    logic               is_pattern;

    assign is_pattern = (item.req_type == REQ_PATTERN);
    assign is_star_c  = (item.char_code == STAR_CODE);

    // A pattern item that finds no load in progress starts a fresh pattern.
    assign load_base  = loading_reg ? len_reg : '0;
    assign ovf_base   = loading_reg & ovf_reg;
    assign cl0_base   = loading_reg ? cl0_reg : (PAT_MAX + 1)'(1);
    assign store_full = (load_base == LEN_W'(PAT_MAX));
    assign wr_en      = step & is_pattern & ~item.no_char & ~store_full;

    always_comb
    begin
        cl0_ext = '0;
        for (int p = 0; p < PAT_MAX; p++)
        begin
            cl0_ext[p+1] = (load_base == LEN_W'(p)) & cl0_base[p] & is_star_c
                         & ~item.no_char;
        end
    end

    assign cl0_next = cl0_base | cl0_ext;

    always_comb
    begin
        for (int p = 0; p < PAT_MAX; p++)
        begin
            valid_mask[p] = (LEN_W'(p) < len_reg);
            star_v[p]     = valid_mask[p] & star_reg[p];
            lit_match[p]  = valid_mask[p] & ~star_reg[p] & (chr_reg[p] == item.char_code);
        end
    end

    // A text item arriving mid-load ends the pattern first.
    assign act = loading_reg ? cl0_reg : active_reg;

    always_comb
    begin
        seed = '0;
        for (int q = 0; q <= PAT_MAX; q++)
        begin
            if (q < PAT_MAX)
            begin
                seed[q] = seed[q] | (act[q] & star_v[q]);
            end
            if (q > 0)
            begin
                seed[q] = seed[q] | (act[q-1] & lit_match[q-1]);
            end
        end
    end

    swm_closure u_closure
    (
        .seed   (seed),
        .star   (star_v),
        .closed (adv)
    );

    assign cur = item.no_char ? act : adv;

    assign result.matched          = cur[len_reg];
    assign result.pattern_overflow = ovf_reg;

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < PAT_MAX; p++)
        begin
            if (wr_en && (load_base == LEN_W'(p)))
            begin
                chr_reg[p]  <= item.char_code;
                star_reg[p] <= is_star_c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            loading_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            active_reg  <= (PAT_MAX + 1)'(1);
            cl0_reg     <= (PAT_MAX + 1)'(1);
        end
        else if (step)
        begin
            if (is_pattern)
            begin
                len_reg     <= wr_en ? LEN_W'(load_base + 1'b1) : load_base;
                ovf_reg     <= ovf_base | (~item.no_char & store_full);
                loading_reg <= ~item.last;
                cl0_reg     <= cl0_next;
                if (item.last)
                begin
                    active_reg <= cl0_next;
                end
            end
            else
            begin
                loading_reg <= 1'b0;
                active_reg  <= item.last ? cl0_reg : cur;
            end
        end
    end

    a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(PAT_MAX))
        else $error("pattern length beyond store capacity");

    a_cl0_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        cl0_reg[0])
        else $error("restart set lost position zero");

    a_ovf_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (len_reg == LEN_W'(PAT_MAX)))
        else $error("overflow flagged with room left in the store");

    a_text_ends_load: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !is_pattern) |=> !loading_reg)
        else $error("pattern still loading after a text item");

    a_pattern_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (step && is_pattern && item.last) |=> (active_reg == cl0_reg))
        else $error("active set not restarted at pattern end");

endmodule

`default_nettype wire

### design/star_wildcard_matcher.sv
`timescale 1ns / 1ps
`default_nettype none

// Whole-string glob matcher where '*' matches any run of bytes, the empty
// run included, and every other byte matches only itself. Load a pattern
// with items of kind pattern (tuser low), closing it with tlast; then stream
// text items (tuser high) and the item with tlast yields one result with
// the match flag and an overflow flag for patterns longer than 32 bytes.
// An item with no_char set ends an empty pattern or text. The block takes
// one item every cycle, pattern or text, as long as the result side keeps
// up; a final text item that finds the result register still occupied
// stalls the input until that result is taken. Each item waits in an input
// register; the result of a final text item is registered to drive m_tvalid.
// The rate is set by the combinational update of the 33-bit active-position
// vector, which compares the byte against all stored positions in parallel
// and closes the set over stars with a six-level prefix network.
module star_wildcard_matcher
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // char_code[7:0], no_char[8], zero pad
    input  wire logic        s_tuser,   // req_type
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // matched[0], pattern_overflow[1], zero pad
);
    import swm_pkg::*;

    logic        in_valid_reg;
    swm_item_t   item_reg;
    swm_item_t   item_next;
    logic        out_valid_reg;
    swm_result_t out_data_reg;
    swm_result_t result;
    logic        gives_result;
    logic        out_free;
    logic        fire;

    assign item_next.req_type  = req_type_t'(s_tuser);
    assign item_next.char_code = s_tdata[7:0];
    assign item_next.no_char   = s_tdata[8];
    assign item_next.last      = s_tlast;

    assign gives_result = (item_reg.req_type == REQ_TEXT) & item_reg.last;
    assign out_free     = ~out_valid_reg | m_tready;
    assign fire         = in_valid_reg & (~gives_result | out_free);
    assign s_tready     = ~in_valid_reg | fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_next;
        end
    end

    swm_engine u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (fire),
        .item   (item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && gives_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && gives_result)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_data_reg.pattern_overflow, out_data_reg.matched};

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import swm_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;    // char_code[7:0], no_char[8], zero pad
    logic        s_tuser = 1'b0;  // req_type
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // matched[0], pattern_overflow[1], zero pad

    star_wildcard_matcher u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Items waiting to be sent, and match results still due from the block.
    swm_item_t   send_q[$];
    swm_result_t due_results[$];
    swm_item_t   cur_item;
    swm_result_t want;

    // Predicted state of the matcher.
    logic [7:0]       pat_mem[PAT_MAX];
    int               pat_len = 0;
    bit               pat_loading = 1'b0;
    bit               pat_ovf = 1'b0;
    logic [PAT_MAX:0] active_set;

    // Pattern as the generator last built it, used to shape matching texts.
    logic [7:0] gen_pat[$];

    int sent_cnt = 0;
    int total_items = 0;
    int errors = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    bit hold_used = 1'b0;

    // Both sides run without gaps over this stretch of the stimulus.
    wire quiet = (sent_cnt >= 350) && (sent_cnt < 450);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [PAT_MAX:0] star_closure(logic [PAT_MAX:0] set);
        for (int p = 0; p < PAT_MAX; p++)
        begin
            if (p < pat_len && set[p] && pat_mem[p] == STAR_CODE)
                set[p + 1] = 1'b1;
        end
        return set;
    endfunction

    function automatic void glob_step(swm_item_t it);
        logic [PAT_MAX:0] nxt;
        swm_result_t res;
        if (it.req_type == REQ_PATTERN)
        begin
            if (!pat_loading)
            begin
                pat_len = 0;
                pat_ovf = 1'b0;
                pat_loading = 1'b1;
            end
            if (!it.no_char)
            begin
                if (pat_len < PAT_MAX)
                begin
                    pat_mem[pat_len] = it.char_code;
                    pat_len++;
                end
                else
                    pat_ovf = 1'b1;
            end
            if (it.last)
            begin
                pat_loading = 1'b0;
                active_set = star_closure((PAT_MAX + 1)'(1));
            end
        end
        else
        begin
            // A text item closes a pattern that is still being loaded.
            if (pat_loading)
            begin
                pat_loading = 1'b0;
                active_set = star_closure((PAT_MAX + 1)'(1));
            end
            if (!it.no_char)
            begin
                nxt = '0;
                for (int p = 0; p < PAT_MAX; p++)
                begin
                    if (p < pat_len && active_set[p])
                    begin
                        if (pat_mem[p] == STAR_CODE)
                            nxt[p] = 1'b1;
                        else if (pat_mem[p] == it.char_code)
                            nxt[p + 1] = 1'b1;
                    end
                end
                active_set = star_closure(nxt);
            end
            if (it.last)
            begin
                res.matched = active_set[pat_len];
                res.pattern_overflow = pat_ovf;
                due_results.push_back(res);
                active_set = star_closure((PAT_MAX + 1)'(1));
            end
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t: mismatch: %s", $time, msg);
        errors++;
    endtask

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] pick_pattern_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return STAR_CODE;
        if (r < 80)
            return 8'h61 + 8'($urandom_range(0, 2));
        return rnd_byte();
    endfunction

    function automatic logic [7:0] pick_text_char();
        if ($urandom_range(0, 99) < 85)
            return 8'h61 + 8'($urandom_range(0, 2));
        return rnd_byte();
    endfunction

    task automatic push_item(req_type_t kind, logic [7:0] code, logic empty, logic fin);
        swm_item_t it;
        it.req_type = kind;
        it.char_code = code;
        it.no_char = empty;
        it.last = fin;
        send_q.push_back(it);
    endtask

    task automatic gen_pattern(int len, bit closed);
        logic [7:0] c;
        bit tail_empty;
        tail_empty = (len == 0) || ($urandom_range(0, 4) == 0);
        gen_pat.delete();
        for (int i = 0; i < len; i++)
        begin
            c = pick_pattern_char();
            if ($urandom_range(0, 19) == 0)
                push_item(REQ_PATTERN, rnd_byte(), 1'b1, 1'b0);
            if (gen_pat.size() < PAT_MAX)
                gen_pat.push_back(c);
            push_item(REQ_PATTERN, c, 1'b0, closed && !tail_empty && i == len - 1);
        end
        if (closed && tail_empty)
            push_item(REQ_PATTERN, rnd_byte(), 1'b1, 1'b1);
    endtask

    // Mostly texts built from the current pattern, so that many of them match.
    task automatic gen_text();
        logic [7:0] txt[$];
        int unsigned n;
        bit tail_empty;
        if ($urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(0, 8);
            repeat (n) txt.push_back(pick_text_char());
        end
        else
        begin
            foreach (gen_pat[i])
            begin
                if (gen_pat[i] == STAR_CODE)
                    repeat ($urandom_range(0, 3)) txt.push_back(pick_text_char());
                else
                    txt.push_back(gen_pat[i]);
            end
            if (txt.size() > 0 && $urandom_range(0, 2) == 0)
                txt[$urandom_range(0, txt.size() - 1)] = pick_text_char();
        end
        tail_empty = (txt.size() == 0) || ($urandom_range(0, 6) == 0);
        foreach (txt[i])
        begin
            if ($urandom_range(0, 19) == 0)
                push_item(REQ_TEXT, rnd_byte(), 1'b1, 1'b0);
            push_item(REQ_TEXT, txt[i], 1'b0, !tail_empty && i == txt.size() - 1);
        end
        if (tail_empty)
            push_item(REQ_TEXT, rnd_byte(), 1'b1, 1'b1);
    endtask

    // Driver: one item on offer at a time, the next one loaded on acceptance.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                glob_step(cur_item);
                sent_cnt <= sent_cnt + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 25))
                begin
                    cur_item = send_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {7'd0, cur_item.no_char, cur_item.char_code};
                    s_tuser <= cur_item.req_type;
                    s_tlast <= cur_item.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // One long hold-off of the result side while the driver keeps sending.
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (!hold_used && sent_cnt >= 200)
        begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Monitor on the result side.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                else
                begin
                    want = due_results.pop_front();
                    if (m_tdata[0] !== want.matched)
                        report_mismatch($sformatf("matched %b, want %b",
                                                  m_tdata[0], want.matched));
                    if (m_tdata[1] !== want.pattern_overflow)
                        report_mismatch($sformatf("pattern_overflow %b, want %b",
                                                  m_tdata[1], want.pattern_overflow));
                end
            end
            m_tready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= 25);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d cycles without progress", idle_cycles);
                $display("[star_wildcard_matcher] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned r;
        int len;
        bit open_pat;

        active_set = (PAT_MAX + 1)'(1);

        // Empty pattern after reset: only the empty text matches.
        push_item(REQ_TEXT, rnd_byte(), 1'b1, 1'b1);
        push_item(REQ_TEXT, 8'h61, 1'b0, 1'b1);
        // A lone star matches the empty text and any text.
        push_item(REQ_PATTERN, STAR_CODE, 1'b0, 1'b1);
        push_item(REQ_TEXT, rnd_byte(), 1'b1, 1'b1);
        push_item(REQ_TEXT, 8'h78, 1'b0, 1'b0);
        push_item(REQ_TEXT, 8'h79, 1'b0, 1'b1);
        // Explicitly empty pattern.
        push_item(REQ_PATTERN, rnd_byte(), 1'b1, 1'b1);
        push_item(REQ_TEXT, 8'hFF, 1'b0, 1'b1);
        // Extreme byte values around a star, with an empty text item inside.
        push_item(REQ_PATTERN, 8'h01, 1'b0, 1'b0);
        push_item(REQ_PATTERN, STAR_CODE, 1'b0, 1'b0);
        push_item(REQ_PATTERN, 8'hFF, 1'b0, 1'b1);
        push_item(REQ_TEXT, 8'h01, 1'b0, 1'b0);
        push_item(REQ_TEXT, 8'h55, 1'b0, 1'b0);
        push_item(REQ_TEXT, rnd_byte(), 1'b1, 1'b0);
        push_item(REQ_TEXT, 8'hFF, 1'b0, 1'b1);
        // Pattern opened by an empty item and ended by a text item.
        push_item(REQ_PATTERN, rnd_byte(), 1'b1, 1'b0);
        push_item(REQ_PATTERN, 8'h71, 1'b0, 1'b0);
        push_item(REQ_TEXT, 8'h71, 1'b0, 1'b1);
        push_item(REQ_TEXT, 8'h71, 1'b0, 1'b0);
        push_item(REQ_TEXT, 8'h71, 1'b0, 1'b1);
        // Two stars in a row.
        push_item(REQ_PATTERN, STAR_CODE, 1'b0, 1'b0);
        push_item(REQ_PATTERN, STAR_CODE, 1'b0, 1'b1);
        push_item(REQ_TEXT, 8'h7A, 1'b0, 1'b1);
        push_item(REQ_TEXT, rnd_byte(), 1'b1, 1'b0);

        // A pattern past the store's capacity, then a short one that clears it.
        gen_pattern(PAT_MAX + 2, 1'b1);
        gen_text();
        gen_pattern(3, 1'b1);
        gen_text();

        while (send_q.size() < 560)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                push_item(req_type_t'($urandom_range(0, 1)), rnd_byte(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if (r < 35)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40)
                                                  : $urandom_range(0, 8);
                open_pat = (len > 0) && ($urandom_range(0, 9) == 0);
                gen_pattern(len, !open_pat);
                if (open_pat)
                    gen_text();
            end
            else
                gen_text();
        end
        total_items = send_q.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_cnt < total_items)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("[star_wildcard_matcher] OK");
        else
            $display("[star_wildcard_matcher] ERROR");
        $finish;
    end

endmodule

### files.f
design/swm_pkg.sv
design/swm_closure.sv
design/swm_engine.sv
design/star_wildcard_matcher.sv
sim/tb.sv
